// ===== hdl/obstacle_avoid_sequencer_top_macros.svh =====
// Assertion helpers shared by the sequencer RTL.
// Each expects a clock named clk and a synchronous reset named rst in scope.
`ifndef OBSTACLE_AVOID_SEQUENCER_TOP_MACROS_SVH
`define OBSTACLE_AVOID_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define OAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/oas_pkg.sv =====
package oas_pkg;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_DRIFT   = 3'd1;
  localparam phase_t PH_FORWARD = 3'd2;
  localparam phase_t PH_TURN    = 3'd3;
  localparam phase_t PH_REJOIN  = 3'd4;

  // consecutive line ticks that end the rejoin phase
  localparam logic [7:0] LINE_DEBOUNCE = 8'd3;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_AVOID_DIST     = 3'd0;
  localparam cfg_idx_t CFG_DRIFT_TIME     = 3'd1;
  localparam cfg_idx_t CFG_FORWARD_TMO    = 3'd2;
  localparam cfg_idx_t CFG_TURN_TIME      = 3'd3;
  localparam cfg_idx_t CFG_REJOIN_TMO     = 3'd4;
  localparam cfg_idx_t CFG_FULL_SPEED     = 3'd5;
  localparam cfg_idx_t CFG_SOFT_SPEED     = 3'd6;
  localparam cfg_idx_t CFG_IR_CLEAR_COUNT = 3'd7;

  typedef struct packed {
    logic [11:0] avoid_dist_mm;
    logic [31:0] drift_time_us;
    logic [31:0] forward_timeout_us;
    logic [31:0] turn_time_us;
    logic [31:0] rejoin_timeout_us;
    logic [6:0]  cruise_spd;
    logic [6:0]  inner_spd;
    logic [7:0]  ir_clear_count;
  } cfg_t;

  // packed high to low so that line_mid lands in bit 0
  typedef struct packed {
    logic [11:0] dist_mm;
    logic        dist_valid;
    logic [31:0] now_us;
    logic        ir_right;
    logic        ir_left;
    logic        line_mid;
  } item_t;

  typedef struct packed {
    phase_t      phase_out;
    logic        avoid_active;
    logic        rr_back;
    logic [6:0]  rr_spd;
    logic        rl_back;
    logic [6:0]  rl_spd;
    logic        fr_back;
    logic [6:0]  fr_spd;
    logic        fl_back;
    logic [6:0]  fl_spd;
    logic        drive_valid;
  } result_t;

  localparam int ITEM_W   = $bits(item_t);
  localparam int RESULT_W = $bits(result_t);
  localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== hdl/oas_cfg.sv =====
module oas_cfg
  import oas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  cfg_idx_t    wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.avoid_dist_mm      <= 12'd200;
      cfg.drift_time_us      <= 32'd500000;
      cfg.forward_timeout_us <= 32'd2000000;
      cfg.turn_time_us       <= 32'd500000;
      cfg.rejoin_timeout_us  <= 32'd3000000;
      cfg.cruise_spd         <= 7'd100;
      cfg.inner_spd          <= 7'd50;
      cfg.ir_clear_count     <= 8'd3;
    end else if (wr_en) begin
      case (wr_index)
        CFG_AVOID_DIST:     cfg.avoid_dist_mm      <= wr_data[11:0];
        CFG_DRIFT_TIME:     cfg.drift_time_us      <= wr_data;
        CFG_FORWARD_TMO:    cfg.forward_timeout_us <= wr_data;
        CFG_TURN_TIME:      cfg.turn_time_us       <= wr_data;
        CFG_REJOIN_TMO:     cfg.rejoin_timeout_us  <= wr_data;
        CFG_FULL_SPEED:     cfg.cruise_spd         <= wr_data[6:0];
        CFG_SOFT_SPEED:     cfg.inner_spd          <= wr_data[6:0];
        CFG_IR_CLEAR_COUNT: cfg.ir_clear_count     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/oas_seq.sv =====
module oas_seq
  import oas_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    step,
  output result_t res
);

  typedef struct packed {
    phase_t      phase;
    logic [31:0] phase_start;
    logic        passed_flag;
    logic        ir_seen;
    logic [7:0]  ir_clear_streak;
    logic [7:0]  line_streak;
  } seq_state_t;

  seq_state_t st, st_next;

  logic        triggered;
  logic        cleared;
  logic        ir_obstructed;
  logic [6:0]  full, inner, drift;
  logic [6:0]  full_less;
  logic [31:0] elapsed;

  function automatic logic [6:0] clamp100(input logic [6:0] v);
    clamp100 = (v > 7'd100) ? 7'd100 : v;
  endfunction

  function automatic result_t wheels(input logic [6:0] fl, input logic flb,
                                     input logic [6:0] fr, input logic frb,
                                     input logic [6:0] rl, input logic rlb,
                                     input logic [6:0] rr, input logic rrb);
    result_t r;
    r = '0;
    r.drive_valid = 1'b1;
    r.fl_spd = fl; r.fl_back = flb;
    r.fr_spd = fr; r.fr_back = frb;
    r.rl_spd = rl; r.rl_back = rlb;
    r.rr_spd = rr; r.rr_back = rrb;
    wheels = r;
  endfunction

  assign triggered  = item.dist_valid && (item.dist_mm != 12'd0) &&
                      (item.dist_mm <= cfg.avoid_dist_mm);
  // clear threshold can exceed 12 bits
  assign cleared    = item.dist_valid &&
                      ({1'b0, item.dist_mm} > ({1'b0, cfg.avoid_dist_mm} + 13'd100));
  assign ir_obstructed = item.ir_left | item.ir_right;
  assign full       = clamp100(cfg.cruise_spd);
  assign inner      = clamp100(cfg.inner_spd);
  assign full_less  = cfg.cruise_spd - 7'd20;
  assign drift      = (cfg.cruise_spd > 7'd20) ? clamp100(full_less) : 7'd0;

  always_comb begin
    st_next = st;
    res     = '0;
    elapsed = '0;

    if (st_next.phase == PH_IDLE || st_next.phase > PH_REJOIN) begin
      st_next.phase = PH_IDLE;
      if (triggered) begin
        st_next.phase           = PH_DRIFT;
        st_next.passed_flag     = 1'b0;
        st_next.ir_seen         = 1'b0;
        st_next.ir_clear_streak = 8'd0;
        st_next.line_streak     = 8'd0;
      end
    end

    case (st_next.phase)
      PH_DRIFT: begin
        res = wheels(full, 1'b0, drift, 1'b1, drift, 1'b1, drift, 1'b0);
        if (cleared && !st_next.passed_flag) begin
          st_next.phase_start = item.now_us;
          st_next.passed_flag = 1'b1;
        end
        elapsed = item.now_us - st_next.phase_start;
        if (st_next.passed_flag && elapsed >= cfg.drift_time_us) begin
          st_next.phase           = PH_FORWARD;
          st_next.phase_start     = item.now_us;
          st_next.ir_seen         = 1'b0;
          st_next.ir_clear_streak = 8'd0;
        end
      end
      PH_FORWARD: begin
        res = wheels(full, 1'b0, full, 1'b0, full, 1'b0, full, 1'b0);
        if (ir_obstructed) begin
          st_next.ir_seen         = 1'b1;
          st_next.ir_clear_streak = 8'd0;
        end else if (st_next.ir_seen && st_next.ir_clear_streak != 8'hFF) begin
          st_next.ir_clear_streak = st_next.ir_clear_streak + 8'd1;
        end
        elapsed = item.now_us - st_next.phase_start;
        if ((st_next.ir_seen && st_next.ir_clear_streak >= cfg.ir_clear_count) ||
            elapsed >= cfg.forward_timeout_us) begin
          st_next.phase       = PH_TURN;
          st_next.phase_start = item.now_us;
        end
      end
      PH_TURN: begin
        res = wheels(inner, 1'b1, full, 1'b0, inner, 1'b1, full, 1'b0);
        elapsed = item.now_us - st_next.phase_start;
        if (elapsed >= cfg.turn_time_us) begin
          st_next.phase       = PH_REJOIN;
          st_next.phase_start = item.now_us;
          st_next.line_streak = 8'd0;
        end
      end
      PH_REJOIN: begin
        res = wheels(full, 1'b0, full, 1'b0, full, 1'b0, full, 1'b0);
        // line sensor is active low
        if (!item.line_mid) begin
          if (st_next.line_streak != 8'hFF) st_next.line_streak = st_next.line_streak + 8'd1;
        end else begin
          st_next.line_streak = 8'd0;
        end
        elapsed = item.now_us - st_next.phase_start;
        if (st_next.line_streak >= LINE_DEBOUNCE || elapsed >= cfg.rejoin_timeout_us) begin
          st_next = '0;
        end
      end
      default: ;
    endcase

    res.avoid_active = (st_next.phase != PH_IDLE);
    res.phase_out    = st_next.phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

// ===== hdl/obstacle_avoid_sequencer_top.sv =====
// Obstacle avoidance sequencer for a four-wheel drive base.
// Slave stream (s_*): one control tick per transfer carrying line, IR, time and
// ultrasonic distance. Master stream (m_*): one result per tick with the four
// wheel commands, the active flag and the phase after the tick.
// Config channel (cfg_*): register index and data, taken whenever cfg_valid is
// high; write only while no tick is in flight.
// A tick passes through the input register and then the result register before
// its result appears on m_*. Throughput: one tick per cycle while m_tready is
// high; the whole sequencer step is a single combinational pass (one 32-bit
// subtract and compare per phase) between the two registers.
// If m_tready is low the result holds, the input register still takes one more
// tick, then s_tready drops until the result is taken.
// Reset clears both stages, puts the sequence in idle with all streaks and
// flags at zero, and loads the register defaults.
module obstacle_avoid_sequencer_top
  import oas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // line_mid, ir_left, ir_right, now_us[31:0], dist_valid, dist_mm[11:0]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // drive_valid, fl_spd[6:0], fl_back, fr_spd[6:0], fr_back, rl_spd[6:0],
  // rl_back, rr_spd[6:0], rr_back, avoid_active, phase_out[2:0], zero pad
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  cfg_idx_t               cfg_index,
  input  logic [31:0]            cfg_data
);

`include "obstacle_avoid_sequencer_top_macros.svh"

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t step_res;
  result_t out_res;
  logic    out_valid;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_res};

  oas_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  oas_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .step (advance),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (!out_valid || m_tready) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_item <= s_tdata[ITEM_W-1:0];
    if (advance) out_res <= step_res;
  end

  `OAS_ASSERT_IMP(a_idle_no_drive, out_valid && !out_res.drive_valid, out_res.phase_out == PH_IDLE && out_res.fl_spd == 7'd0 && out_res.rr_spd == 7'd0, "idle result carries wheel data")
  `OAS_ASSERT_IMP(a_active_phase, out_valid, out_res.avoid_active == (out_res.phase_out != PH_IDLE), "active flag disagrees with phase")
  `OAS_ASSERT_NXT(a_hold_pending, in_valid && !advance, in_valid && $stable(in_item), "pending tick lost while result stalled")
  `OAS_ASSERT_NXT(a_result_loaded, advance, out_valid, "stepped tick produced no result")

endmodule
